// File: src/sdtc_pkg.sv
// Package for the SPI DMA transfer controller.
// Shared types, codes and sizes; used by every module in src.
package sdtc_pkg;

  // input opcodes
  localparam logic [1:0] OP_REG_RD  = 2'd0;
  localparam logic [1:0] OP_REG_WR  = 2'd1;
  localparam logic [1:0] OP_MEM_RET = 2'd2;
  localparam logic [1:0] OP_SPI_RET = 2'd3;

  // register byte offsets
  localparam logic [3:0] REG_CTRL = 4'd0;
  localparam logic [3:0] REG_SRC  = 4'd4;
  localparam logic [3:0] REG_SNK  = 4'd8;

  localparam int GO_BIT    = 16;
  localparam int CNT_W     = 16;
  localparam int TOP_LANE  = 24;
  localparam logic [31:0] ADDR_ALIGN = 32'hFFFF_FFFC;
  localparam logic [31:0] WORD_STEP  = 32'd4;

  // result queue sizing: three results at most per request
  localparam int MAX_RES = 3;
  localparam int QDEPTH  = 8;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    KIND_RDATA = 3'd0,
    KIND_MRD   = 3'd1,
    KIND_MWR   = 3'd2,
    KIND_SPI   = 3'd3,
    KIND_CS    = 3'd4,
    KIND_IRQ   = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] read_data;
    logic [31:0] mem_address;
    logic [31:0] mem_write_data;
    logic [7:0]  spi_tx_byte;
    logic        chip_select;
    logic        last;
  } result_t;

  // results produced by one request, slot 0 first
  typedef struct packed {
    logic [1:0]            n;
    result_t [MAX_RES-1:0] res;
  } push_t;

endpackage

// File: src/sdtc_if.sv
// Channel interfaces for the SPI DMA transfer controller.
// Independent of sdtc_pkg; field widths are given literally.
interface sdtc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [3:0]  reg_offset;
  logic [31:0] write_value;
  logic [31:0] mem_word;
  logic [7:0]  spi_rx_byte;

  modport source (output valid, opcode, reg_offset, write_value, mem_word, spi_rx_byte,
                  input ready);
  modport sink   (input valid, opcode, reg_offset, write_value, mem_word, spi_rx_byte,
                  output ready);
endinterface

interface sdtc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] read_data;
  logic [31:0] mem_address;
  logic [31:0] mem_write_data;
  logic [7:0]  spi_tx_byte;
  logic        chip_select;
  logic        last;

  modport source (output valid, kind, read_data, mem_address, mem_write_data, spi_tx_byte,
                  chip_select, last, input ready);
  modport sink   (input valid, kind, read_data, mem_address, mem_write_data, spi_tx_byte,
                  chip_select, last, output ready);
endinterface

// File: src/sdtc_engine.sv
// Request register, register file and transfer state of the SPI DMA controller.
// Depends on sdtc_pkg and sdtc_in_if; feeds sdtc_result_queue.
module sdtc_engine (
  input  logic                       clk,
  input  logic                       rst_n,
  sdtc_in_if.sink                    in_ch,
  input  logic [sdtc_pkg::QCNT_W-1:0] q_count,
  output sdtc_pkg::push_t            push
);

  // held request
  logic        hv_r;
  logic [1:0]  op_r;
  logic [3:0]  off_r;
  logic [31:0] wv_r;
  logic [31:0] mw_r;
  logic [7:0]  rx_r;

  // architectural state
  logic [15:0] ctrl_r,      ctrl_nxt;
  logic [31:0] src_r,       src_nxt;
  logic [31:0] snk_r,       snk_nxt;
  logic        busy_r,      busy_nxt;
  logic [15:0] left_r,      left_nxt;
  logic [31:0] cur_src_r,   cur_src_nxt;
  logic [31:0] cur_snk_r,   cur_snk_nxt;
  logic [31:0] send_r,      send_nxt;
  logic [31:0] recv_r,      recv_nxt;
  logic [1:0]  slot_r,      slot_nxt;
  logic        await_r,     await_nxt;

  logic [sdtc_pkg::QCNT_W-1:0] fill_after;

  // room must remain for a full request's worth of results
  assign fill_after  = q_count + sdtc_pkg::QCNT_W'(push.n);
  assign in_ch.ready = fill_after <= sdtc_pkg::QCNT_W'(sdtc_pkg::QDEPTH - sdtc_pkg::MAX_RES);

  always_comb begin
    logic [31:0]       rd_v;
    logic [15:0]       left_dec;
    logic [31:0]       recv_new;
    sdtc_pkg::push_t   p;
    p           = '0;
    rd_v        = '0;
    left_dec    = left_r - 16'd1;
    recv_new    = {rx_r, recv_r[31:8]};
    ctrl_nxt    = ctrl_r;
    src_nxt     = src_r;
    snk_nxt     = snk_r;
    busy_nxt    = busy_r;
    left_nxt    = left_r;
    cur_src_nxt = cur_src_r;
    cur_snk_nxt = cur_snk_r;
    send_nxt    = send_r;
    recv_nxt    = recv_r;
    slot_nxt    = slot_r;
    await_nxt   = await_r;
    if (hv_r) begin
      case (op_r)
        sdtc_pkg::OP_REG_RD: begin
          case (off_r)
            sdtc_pkg::REG_CTRL: rd_v = {16'd0, ctrl_r};
            sdtc_pkg::REG_SRC:  rd_v = src_r;
            sdtc_pkg::REG_SNK:  rd_v = snk_r;
            default:            rd_v = '0;
          endcase
          p.res[0].kind      = sdtc_pkg::KIND_RDATA;
          p.res[0].read_data = rd_v;
          p.n                = 2'd1;
        end
        sdtc_pkg::OP_REG_WR: begin
          case (off_r)
            sdtc_pkg::REG_SRC: src_nxt = wv_r;
            sdtc_pkg::REG_SNK: snk_nxt = wv_r;
            sdtc_pkg::REG_CTRL: begin
              ctrl_nxt = wv_r[15:0];
              if (wv_r[sdtc_pkg::GO_BIT] && !busy_r) begin
                left_nxt    = wv_r[15:0];
                cur_src_nxt = src_r & sdtc_pkg::ADDR_ALIGN;
                cur_snk_nxt = snk_r & sdtc_pkg::ADDR_ALIGN;
                p.res[0].kind        = sdtc_pkg::KIND_CS;
                p.res[0].chip_select = 1'b1;
                if (wv_r[15:0] == 16'd0) begin
                  p.res[1].kind = sdtc_pkg::KIND_CS;
                  p.res[2].kind = sdtc_pkg::KIND_IRQ;
                  p.n           = 2'd3;
                end else begin
                  busy_nxt             = 1'b1;
                  await_nxt            = 1'b0;
                  p.res[1].kind        = sdtc_pkg::KIND_MRD;
                  p.res[1].mem_address = src_r & sdtc_pkg::ADDR_ALIGN;
                  p.n                  = 2'd2;
                end
              end
            end
            default: ;
          endcase
        end
        sdtc_pkg::OP_MEM_RET: begin
          if (busy_r && !await_r) begin
            send_nxt             = mw_r;
            recv_nxt             = '0;
            slot_nxt             = '0;
            await_nxt            = 1'b1;
            p.res[0].kind        = sdtc_pkg::KIND_SPI;
            p.res[0].spi_tx_byte = mw_r[7:0];
            p.n                  = 2'd1;
          end
        end
        sdtc_pkg::OP_SPI_RET: begin
          if (busy_r && await_r) begin
            recv_nxt = recv_new;
            send_nxt = {8'd0, send_r[31:8]};
            left_nxt = left_dec;
            slot_nxt = slot_r + 2'd1;
            if (slot_r == 2'd3 || left_dec == 16'd0) begin
              // word done: store it, step both addresses
              p.res[0].kind           = sdtc_pkg::KIND_MWR;
              p.res[0].mem_address    = cur_snk_r;
              p.res[0].mem_write_data = recv_new;
              cur_src_nxt             = cur_src_r + sdtc_pkg::WORD_STEP;
              cur_snk_nxt             = cur_snk_r + sdtc_pkg::WORD_STEP;
              await_nxt               = 1'b0;
              if (left_dec == 16'd0) begin
                busy_nxt      = 1'b0;
                p.res[1].kind = sdtc_pkg::KIND_CS;
                p.res[2].kind = sdtc_pkg::KIND_IRQ;
                p.n           = 2'd3;
              end else begin
                p.res[1].kind        = sdtc_pkg::KIND_MRD;
                p.res[1].mem_address = cur_src_r + sdtc_pkg::WORD_STEP;
                p.n                  = 2'd2;
              end
            end else begin
              p.res[0].kind        = sdtc_pkg::KIND_SPI;
              p.res[0].spi_tx_byte = send_r[15:8];
              p.n                  = 2'd1;
            end
          end
        end
        default: ;
      endcase
    end
    for (int i = 0; i < sdtc_pkg::MAX_RES; i++) begin
      if (p.n != 2'd0 && 2'(i) == p.n - 2'd1) p.res[i].last = 1'b1;
    end
    push = p;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r      <= 1'b0;
      ctrl_r    <= '0;
      src_r     <= '0;
      snk_r     <= '0;
      busy_r    <= 1'b0;
      left_r    <= '0;
      cur_src_r <= '0;
      cur_snk_r <= '0;
      send_r    <= '0;
      recv_r    <= '0;
      slot_r    <= '0;
      await_r   <= 1'b0;
    end else begin
      hv_r      <= in_ch.valid && in_ch.ready;
      ctrl_r    <= ctrl_nxt;
      src_r     <= src_nxt;
      snk_r     <= snk_nxt;
      busy_r    <= busy_nxt;
      left_r    <= left_nxt;
      cur_src_r <= cur_src_nxt;
      cur_snk_r <= cur_snk_nxt;
      send_r    <= send_nxt;
      recv_r    <= recv_nxt;
      slot_r    <= slot_nxt;
      await_r   <= await_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_r  <= in_ch.opcode;
      off_r <= in_ch.reg_offset;
      wv_r  <= in_ch.write_value;
      mw_r  <= in_ch.mem_word;
      rx_r  <= in_ch.spi_rx_byte;
    end
  end

  // waiting on an SPI byte only happens inside a transfer
  a_await_busy: assert property (@(posedge clk) disable iff (!rst_n) await_r |-> busy_r)
    else $error("awaiting SPI byte while idle");

  // a transfer ends only together with the interrupt
  a_end_irq: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> $past(push.n == 2'd3 && push.res[2].kind == sdtc_pkg::KIND_IRQ))
    else $error("transfer ended without interrupt");

  // a transfer in progress always has bytes outstanding
  a_busy_left: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> left_r != 16'd0)
    else $error("busy with zero bytes left");

endmodule

// File: src/sdtc_result_queue.sv
// Result queue: takes up to three results a cycle, hands out one per request.
// Depends on sdtc_pkg and sdtc_out_if.
module sdtc_result_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sdtc_pkg::push_t             push,
  output logic [sdtc_pkg::QCNT_W-1:0] q_count,
  sdtc_out_if.source                  out_ch
);

  sdtc_pkg::result_t mem [sdtc_pkg::QDEPTH];

  logic [sdtc_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [sdtc_pkg::QCNT_W-1:0] count_r, count_nxt;
  logic                        pop;
  sdtc_pkg::result_t           head;

  assign pop       = out_ch.valid && out_ch.ready;
  assign count_nxt = count_r + sdtc_pkg::QCNT_W'(push.n) - sdtc_pkg::QCNT_W'(pop);
  assign q_count   = count_r;
  assign head      = mem[rd_ptr_r];

  assign out_ch.valid          = count_r != '0;
  assign out_ch.kind           = head.kind;
  assign out_ch.read_data      = head.read_data;
  assign out_ch.mem_address    = head.mem_address;
  assign out_ch.mem_write_data = head.mem_write_data;
  assign out_ch.spi_tx_byte    = head.spi_tx_byte;
  assign out_ch.chip_select    = head.chip_select;
  assign out_ch.last           = head.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + sdtc_pkg::QPTR_W'(push.n);
      rd_ptr_r <= rd_ptr_r + sdtc_pkg::QPTR_W'(pop);
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < sdtc_pkg::MAX_RES; i++) begin
      if (2'(i) < push.n) mem[wr_ptr_r + sdtc_pkg::QPTR_W'(i)] <= push.res[i];
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r + sdtc_pkg::QCNT_W'(push.n) <= sdtc_pkg::QCNT_W'(sdtc_pkg::QDEPTH))
    else $error("result queue overflow");

  a_fill_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0 && !pop) |=> count_r == $past(count_r) + sdtc_pkg::QCNT_W'($past(push.n)))
    else $error("result queue count out of step");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != sdtc_pkg::QCNT_W'(sdtc_pkg::QDEPTH) |->
      sdtc_pkg::QPTR_W'(count_r) == wr_ptr_r - rd_ptr_r)
    else $error("result queue pointers disagree with count");

endmodule

// File: src/spi_dma_transfer_controller_unit.sv
// SPI DMA transfer controller, top level.
// Depends on sdtc_pkg, sdtc_if, sdtc_engine and sdtc_result_queue.
//
// Usage:
//   in_ch  - event requests: register read/write, memory word returned,
//            SPI byte returned. Accepted when valid and ready are high.
//   out_ch - result requests: read data, memory read/write, SPI send,
//            chip select, interrupt. One result per handshake; last marks
//            the final result caused by one input request.
// Path: an accepted request is held in the request register; its zero to
//   three results are then written into the result queue, from which the
//   first is offered on out_ch.
// Throughput: one input request per cycle; one result per cycle out. The
//   8-entry result queue sets the limit: in_ch.ready drops when the queue
//   could not take a full set of three more results.
// Reset: synchronous, active low. Clears the register file, the transfer state, the
//   request valid flag and the queue count and pointers; out_ch.valid is low after reset.
// Stall: while out_ch.ready is low results pile up in the queue and input
//   is throttled; nothing is dropped or repeated.
module spi_dma_transfer_controller_unit (
  input  logic       clk,
  input  logic       rst_n,
  sdtc_in_if.sink    in_ch,
  sdtc_out_if.source out_ch
);

  sdtc_pkg::push_t             push;
  logic [sdtc_pkg::QCNT_W-1:0] q_count;

  // request register + control/transfer state
  sdtc_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_count (q_count),
    .push    (push)
  );

  // multi-push result queue, doubles as the output register
  sdtc_result_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .q_count (q_count),
    .out_ch  (out_ch)
  );

endmodule
